>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define RLDI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define RLDI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rldi_pkg.sv
// ----------------------------------------------------------------------------
// rldi_pkg
// Sizes, character codes and command codes of the run-length decoder.
// ----------------------------------------------------------------------------
package rldi_pkg;

  // Entry table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(TABLE_DEPTH);

  // Run count width and the widened product used for count*10+digit.
  localparam int COUNT_WIDTH = 32;
  localparam int PROD_W      = COUNT_WIDTH + 4;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Character codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NONE  = 8'h00;

  // Command codes.
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_t;

endpackage

>>> hdl/run_length_decode_iterator_unit.sv
// ----------------------------------------------------------------------------
// run_length_decode_iterator_unit
// Run-length decoder loaded with compressed bytes and drained one letter per
// pull beat. Letters and counts live in two on-chip tables.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports
//  in        sink       in_valid, in_ready, in_cmd, in_byte
//  out       source     out_valid, out_ready, out_char, out_has_more,
//                       out_table_overflow
//
//  One beat is accepted per cycle while the result register is not stalled.
//  The rate is set by the single processing stage between the input register
//  and the result register, which reads the head entry from a registered
//  table read that tracks the read index every cycle.
//  Reset clears the control state; the tables hold garbage until written.
//  A stalled result holds the processing stage, which then holds the input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module run_length_decode_iterator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_has_more,
  output logic       out_table_overflow
);

  localparam int CW = rldi_pkg::COUNT_WIDTH;
  localparam int AW = rldi_pkg::ADDR_W;
  localparam int IW = rldi_pkg::IDX_W;

  // Input register.
  logic       in_valid_r;
  logic       cmd_r;
  logic [7:0] byte_r;

  // Result register.
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_has_more_r;
  logic       out_ovf_r;

  // Decoder state.
  logic [IW-1:0] write_index_r,     write_index_nxt;
  logic [IW-1:0] read_index_r,      read_index_nxt;
  logic          pending_open_r,    pending_open_nxt;
  logic [CW-1:0] pending_count_r,   pending_count_nxt;
  logic [CW-1:0] delivered_count_r, delivered_count_nxt;
  logic          overflow_seen_r,   overflow_seen_nxt;

  // Entry tables and their registered head read.
  logic [7:0]    letter_mem [rldi_pkg::TABLE_DEPTH];
  logic [CW-1:0] count_mem  [rldi_pkg::TABLE_DEPTH];
  logic [7:0]    rd_letter_r;
  logic [CW-1:0] rd_count_r;

  // Processing stage signals.
  logic                       advance;
  logic                       is_digit;
  logic [7:0]                 digit_diff;
  logic [rldi_pkg::PROD_W-1:0] prod_ext;
  logic [rldi_pkg::PROD_W-1:0] prod_sum;
  logic [CW-1:0]              count_sat;
  logic                       do_commit;
  logic                       commit_store;
  logic [IW-1:0]              write_after;
  logic                       letter_we;
  logic [CW-1:0]              head_count;
  logic [7:0]                 char_nxt;
  logic                       has_more_nxt;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  // Input register: take a beat whenever the stage is free or moving on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      byte_r <= in_byte;
    end
  end

  // Digit decode and saturating count*10+digit.
  assign is_digit   = (byte_r >= rldi_pkg::CHAR_ZERO) && (byte_r <= rldi_pkg::CHAR_NINE);
  assign digit_diff = byte_r - rldi_pkg::CHAR_ZERO;
  assign prod_ext   = {4'b0000, pending_count_r};
  assign prod_sum   = (prod_ext << 3) + (prod_ext << 1)
                    + {{(rldi_pkg::PROD_W-4){1'b0}}, digit_diff[3:0]};
  assign count_sat  = (prod_sum[rldi_pkg::PROD_W-1:CW] != 4'b0000)
                    ? rldi_pkg::COUNT_MAX : prod_sum[CW-1:0];

  // The open entry closes on a letter push or on any pull.
  assign do_commit    = advance && ((cmd_r == rldi_pkg::CMD_PULL) || !is_digit);
  assign commit_store = do_commit && pending_open_r && (pending_count_r != '0)
                      && (write_index_r < rldi_pkg::DEPTH_IDX);
  assign write_after  = write_index_r + IW'(commit_store);
  assign letter_we    = advance && (cmd_r == rldi_pkg::CMD_PUSH) && !is_digit
                      && (write_after < rldi_pkg::DEPTH_IDX);

  // A pull may read the entry committed in this very cycle.
  assign head_count = (commit_store && (read_index_r == write_index_r))
                    ? pending_count_r : rd_count_r;

  // Next state and result.
  always_comb begin
    write_index_nxt     = write_index_r;
    read_index_nxt      = read_index_r;
    pending_open_nxt    = pending_open_r;
    pending_count_nxt   = pending_count_r;
    delivered_count_nxt = delivered_count_r;
    overflow_seen_nxt   = overflow_seen_r;
    char_nxt            = rldi_pkg::CHAR_NONE;
    if (advance) begin
      write_index_nxt = write_after;
      case (cmd_r)
        rldi_pkg::CMD_PUSH: begin
          if (is_digit) begin
            if (pending_open_r) begin
              pending_count_nxt = count_sat;
            end
          end else if (letter_we) begin
            pending_open_nxt  = 1'b1;
            pending_count_nxt = '0;
          end else begin
            pending_open_nxt  = 1'b0;
            pending_count_nxt = '0;
            overflow_seen_nxt = 1'b1;
          end
        end
        rldi_pkg::CMD_PULL: begin
          pending_open_nxt  = 1'b0;
          pending_count_nxt = '0;
          if (read_index_r < write_after) begin
            char_nxt = rd_letter_r;
            if ((delivered_count_r + CW'(1)) == head_count) begin
              delivered_count_nxt = '0;
              read_index_nxt      = read_index_r + IW'(1);
            end else begin
              delivered_count_nxt = delivered_count_r + CW'(1);
            end
          end else begin
            char_nxt = rldi_pkg::CHAR_SPACE;
          end
        end
        default: begin
          char_nxt = rldi_pkg::CHAR_NONE;
        end
      endcase
    end
  end

  assign has_more_nxt = (read_index_nxt < write_index_nxt)
                      || (pending_open_nxt && (pending_count_nxt != '0));

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r     <= '0;
      read_index_r      <= '0;
      pending_open_r    <= 1'b0;
      pending_count_r   <= '0;
      delivered_count_r <= '0;
      overflow_seen_r   <= 1'b0;
    end else begin
      write_index_r     <= write_index_nxt;
      read_index_r      <= read_index_nxt;
      pending_open_r    <= pending_open_nxt;
      pending_count_r   <= pending_count_nxt;
      delivered_count_r <= delivered_count_nxt;
      overflow_seen_r   <= overflow_seen_nxt;
    end
  end

  // Entry tables: one write each, head read at the next read index with
  // same-cycle writes forwarded into the read register.
  always_ff @(posedge clk) begin
    if (letter_we) begin
      letter_mem[write_after[AW-1:0]] <= byte_r;
    end
    if (commit_store) begin
      count_mem[write_index_r[AW-1:0]] <= pending_count_r;
    end
    if (letter_we && (write_after == read_index_nxt)) begin
      rd_letter_r <= byte_r;
    end else begin
      rd_letter_r <= letter_mem[read_index_nxt[AW-1:0]];
    end
    if (commit_store && (write_index_r == read_index_nxt)) begin
      rd_count_r <= pending_count_r;
    end else begin
      rd_count_r <= count_mem[read_index_nxt[AW-1:0]];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char_r     <= char_nxt;
      out_has_more_r <= has_more_nxt;
      out_ovf_r      <= overflow_seen_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char           = out_char_r;
  assign out_has_more       = out_has_more_r;
  assign out_table_overflow = out_ovf_r;

  // Checks on the decoder state.
  `RLDI_ASSERT_IMPL(a_read_le_write, 1'b1, read_index_r <= write_index_r, "read index ahead")
  `RLDI_ASSERT_IMPL(a_write_in_range, 1'b1, write_index_r <= rldi_pkg::DEPTH_IDX, "write overrun")
  `RLDI_ASSERT_NEXT(a_overflow_sticky, overflow_seen_r, overflow_seen_r, "overflow flag cleared")
  `RLDI_ASSERT_IMPL(a_partial_live, |delivered_count_r, read_index_r < write_index_r, "stray run")

endmodule

>>> dv/tb_run_length_decode_iterator_unit.sv
// ----------------------------------------------------------------------------
// tb_run_length_decode_iterator_unit
// Self-checking bench for the run-length decoder. A clocked driver feeds push
// and pull beats from a queue that the stimulus block fills up front. A
// clocked monitor compares every result beat with the predicted one. Pacing
// runs through phases with no idling, a slow sender, a slow receiver and
// both, plus long receiver hold-offs and sender pauses that drain the block.
// ----------------------------------------------------------------------------
module tb_run_length_decode_iterator_unit;

  // Sizes taken from the package.
  localparam int TABLE_DEPTH = rldi_pkg::TABLE_DEPTH;
  localparam int COUNT_WIDTH = rldi_pkg::COUNT_WIDTH;
  localparam int PROD_W      = rldi_pkg::PROD_W;

  // Bench sizing.
  localparam int N_RANDOM    = 1850;
  localparam int SEG_LEN     = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One input beat plus its pacing controls.
  typedef struct {
    rldi_pkg::cmd_t cmd;
    logic [7:0]     data;
    idle_mode_t     mode;
    bit             drain;
    bit             hold;
  } beat_t;

  // One predicted result beat.
  typedef struct {
    logic [7:0] ch;
    logic       more;
    logic       ovf;
  } decode_result_t;

  // DUT ports.
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_cmd = rldi_pkg::CMD_PUSH;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_has_more;
  logic       out_table_overflow;

  // Bench bookkeeping.
  beat_t          pending_beats[$];
  decode_result_t expected_results[$];
  int             n_accepted = 0;
  int             n_checked = 0;
  int             n_errors = 0;
  idle_mode_t     pace_mode = IDLE_NONE;
  bit             cur_hold = 1'b0;
  bit             hold_kick = 1'b0;
  int             hold_left = 0;
  int             stall_cycles = 0;

  // Stimulus builder state.
  idle_mode_t gen_mode = IDLE_NONE;
  bit         gen_drain = 1'b0;
  bit         gen_hold = 1'b0;
  int         gen_count = 0;

  // Shadow decoder state.
  logic [7:0]             letter_mem[TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] count_mem[TABLE_DEPTH];
  int                     wr_ptr = 0;
  int                     rd_ptr = 0;
  bit                     run_open = 1'b0;
  logic [COUNT_WIDTH-1:0] run_count = '0;
  logic [COUNT_WIDTH-1:0] given = '0;
  bit                     ovf_seen = 1'b0;
  int                     n_pushes = 0;
  int                     n_pulls = 0;
  int                     n_letters = 0;
  int                     n_dropped = 0;

  run_length_decode_iterator_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char          (out_char),
    .out_has_more      (out_has_more),
    .out_table_overflow(out_table_overflow)
  );

  // Free-running clock.
  always #1 clk = ~clk;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Close the open run, storing it only when its count is nonzero.
  function automatic void close_run();
    if (run_open && run_count != '0 && wr_ptr < TABLE_DEPTH) begin
      count_mem[wr_ptr] = run_count;
      wr_ptr++;
    end
    run_open  = 1'b0;
    run_count = '0;
  endfunction

  // Advance the shadow decoder by one accepted beat.
  function automatic decode_result_t decode_step(rldi_pkg::cmd_t cmd, logic [7:0] data);
    decode_result_t    r;
    logic [PROD_W-1:0] prod;
    r.ch = rldi_pkg::CHAR_NONE;
    if (cmd == rldi_pkg::CMD_PUSH) begin
      n_pushes++;
      if (data >= rldi_pkg::CHAR_ZERO && data <= rldi_pkg::CHAR_NINE) begin
        // Digits only extend an open run; the count saturates.
        if (run_open) begin
          prod = PROD_W'(run_count) * PROD_W'(10)
               + PROD_W'(data - rldi_pkg::CHAR_ZERO);
          run_count = (prod > PROD_W'(rldi_pkg::COUNT_MAX)) ? rldi_pkg::COUNT_MAX
                                                            : prod[COUNT_WIDTH-1:0];
        end
      end else begin
        close_run();
        if (wr_ptr < TABLE_DEPTH) begin
          letter_mem[wr_ptr] = data;
          run_open  = 1'b1;
          run_count = '0;
        end else begin
          ovf_seen = 1'b1;
          n_dropped++;
        end
      end
    end else begin
      n_pulls++;
      close_run();
      if (rd_ptr < wr_ptr) begin
        r.ch = letter_mem[rd_ptr];
        n_letters++;
        given = given + COUNT_WIDTH'(1);
        if (given >= count_mem[rd_ptr]) begin
          given = '0;
          rd_ptr++;
        end
      end else begin
        r.ch = rldi_pkg::CHAR_SPACE;
      end
    end
    r.more = (rd_ptr < wr_ptr) || (run_open && run_count != '0);
    r.ovf  = ovf_seen;
    return r;
  endfunction

  // Append one beat; the pacing flags apply to the next beat only.
  task automatic add_item(rldi_pkg::cmd_t cmd, logic [7:0] data, bit counted);
    beat_t b;
    b.cmd   = cmd;
    b.data  = data;
    b.mode  = gen_mode;
    b.drain = gen_drain;
    b.hold  = gen_hold;
    pending_beats.insert(pending_beats.size(), b);
    gen_drain = 1'b0;
    gen_hold  = 1'b0;
    if (counted) gen_count++;
  endtask

  // Emit leading zeros and then the decimal digits of a count.
  task automatic add_count(longint unsigned v, int zeros);
    logic [7:0] digs[$];
    repeat (zeros) add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO, 1'b1);
    while (v != 0) begin
      digs.push_front(rldi_pkg::CHAR_ZERO + 8'(v % 10));
      v = v / 10;
    end
    foreach (digs[i]) add_item(rldi_pkg::CMD_PUSH, digs[i], 1'b1);
  endtask

  task automatic add_pulls(int n);
    repeat (n) add_item(rldi_pkg::CMD_PULL, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c >= rldi_pkg::CHAR_ZERO && c <= rldi_pkg::CHAR_NINE);
    return c;
  endfunction

  // Driver: predicts each accepted beat and offers the next one.
  always @(posedge clk) begin : drive_beats
    bit    fire;
    bit    offer;
    int    acc_now;
    int    idle_pct;
    beat_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_cmd    <= rldi_pkg::CMD_PUSH;
      in_byte   <= 8'h00;
      hold_kick <= 1'b0;
    end else begin
      fire    = in_valid && in_ready;
      acc_now = n_accepted;
      if (fire) begin
        expected_results.insert(expected_results.size(),
                                decode_step(rldi_pkg::cmd_t'(in_cmd), in_byte));
        acc_now++;
      end
      n_accepted <= acc_now;
      hold_kick  <= fire && cur_hold;
      if (!in_valid || fire) begin
        offer = 1'b0;
        if (pending_beats.size() != 0) begin
          nxt      = pending_beats[0];
          idle_pct = (nxt.mode == IDLE_SENDER) ? 84 : (nxt.mode == IDLE_BOTH) ? 9 : 0;
          // A drain beat waits until every earlier result has been checked.
          offer = !(nxt.drain && acc_now != n_checked) && !roll(idle_pct);
        end
        if (offer) begin
          void'(pending_beats.pop_front());
          in_valid  <= 1'b1;
          in_cmd    <= nxt.cmd;
          in_byte   <= nxt.data;
          pace_mode <= nxt.mode;
          cur_hold  <= nxt.hold;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter, started when a hold beat is accepted.
  always @(posedge clk) begin : hold_off
    if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each result beat against the oldest open prediction.
  always @(posedge clk) begin : check_results
    decode_result_t want;
    int             stall_pct;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (n_checked >= n_accepted) begin
          $display("%0t: unexpected result char=%02h more=%0b ovf=%0b", $time,
                   out_char, out_has_more, out_table_overflow);
          n_errors++;
        end else begin
          want = expected_results[n_checked];
          if (out_char !== want.ch) begin
            $display("%0t: out_char expected %02h actual %02h", $time, want.ch, out_char);
            n_errors++;
          end
          if (out_has_more !== want.more) begin
            $display("%0t: out_has_more expected %0b actual %0b", $time, want.more,
                     out_has_more);
            n_errors++;
          end
          if (out_table_overflow !== want.ovf) begin
            $display("%0t: out_table_overflow expected %0b actual %0b", $time, want.ovf,
                     out_table_overflow);
            n_errors++;
          end
        end
        n_checked <= n_checked + 1;
      end
      stall_pct = (pace_mode == IDLE_RECEIVER) ? 84 : (pace_mode == IDLE_BOTH) ? 9 : 0;
      if (hold_kick || hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= !roll(stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int planned;
    int backlog;
    int seg;
    int cur_seg;
    int n;
    int limit;
    int pick;

    // Directed part: digit before any letter, empty pull, zero count,
    // extreme bytes as letters, leading zero, digit after a pull, drain to
    // exhaustion.
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd5, 1'b0);
    add_item(rldi_pkg::CMD_PULL, 8'hFF, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, 8'h61, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd3, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, 8'h62, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, 8'hFF, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd2, 1'b0);
    add_item(rldi_pkg::CMD_PULL, 8'h00, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd4, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, 8'h00, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd1, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO - 8'd1, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'd1, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_NINE + 8'd1, 1'b0);
    add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_NINE, 1'b0);
    repeat (16) add_item(rldi_pkg::CMD_PULL, 8'($urandom_range(0, 255)), 1'b0);
    planned = 5;
    backlog = 0;
    cur_seg = -1;

    // Random part: fill the table with well-formed runs mixed with pulls
    // and noise, close it with a saturating run, then keep hitting it with
    // dropped letters and pulls.
    while (gen_count < N_RANDOM) begin
      seg = gen_count / SEG_LEN;
      if (seg != cur_seg) begin
        cur_seg   = seg;
        gen_mode  = idle_mode_t'(seg % 4);
        gen_drain = 1'b1;
        gen_hold  = (seg % 8 == 4);
      end
      pick = $urandom_range(0, 99);
      if (planned < TABLE_DEPTH) begin
        if (pick < 50) begin
          add_item(rldi_pkg::CMD_PUSH, random_letter(), 1'b1);
          if (planned == TABLE_DEPTH - 1) begin
            // Last slot gets a count far beyond the counter width.
            add_count(64'd99999999999, 0);
          end else begin
            n = roll(70) ? $urandom_range(1, 9) : $urandom_range(10, 60);
            add_count(n, roll(10) ? $urandom_range(1, 2) : 0);
            backlog += n;
          end
          planned++;
        end else if (pick < 58) begin
          // Run whose count is zero or missing; it is never stored.
          add_item(rldi_pkg::CMD_PUSH, random_letter(), 1'b1);
          add_count(0, $urandom_range(0, 2));
        end else if (pick < 63) begin
          // Digits after a pull have no open run and are ignored.
          add_pulls(1);
          repeat ($urandom_range(1, 3))
            add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        end else begin
          limit = (backlog + 2 > 40) ? 40 : backlog + 2;
          n = $urandom_range(1, limit);
          add_pulls(n);
          backlog = (backlog > n) ? backlog - n : 0;
        end
      end else if (pick < 30) begin
        // Letter against a full table, then digits with nothing open.
        add_item(rldi_pkg::CMD_PUSH, random_letter(), 1'b1);
        repeat ($urandom_range(0, 2))
          add_item(rldi_pkg::CMD_PUSH, rldi_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end else begin
        add_pulls($urandom_range(1, 20));
      end
    end

    // Single reset at the start of the run.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all beats to go in and every result to come back.
    while (pending_beats.size() != 0 || in_valid || n_checked != n_accepted)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d pushes and %0d pulls; %0d letters decoded, %0d dropped.",
             n_pushes, n_pulls, n_letters, n_dropped);
    $display("Table entries stored: %0d of %0d; overflow flag %0b.", wr_ptr, TABLE_DEPTH,
             ovf_seen);
    if (n_errors == 0 && n_checked == n_accepted) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
